// File: rtl/mpad_pkg.sv
// shared constants, register indexes and controller/datapath interface types
package mpad_pkg;

    // default geometry limits
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int MAX_POOL_DEF   = 8;

    // port and field widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int PIXEL_W    = 8;
    localparam int COORD_W    = 10;
    localparam int PLANE_W    = 16;
    localparam int DEQ_W      = 33;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 104;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAD       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_PT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DEQ_EN    = 3'd7;

    // one partial window entry: running max and where it was first seen
    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [PIXEL_W-1:0] value;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic div_step;
        logic bound;
        logic waddr;
        logic wupd;
        logic cand_go;
        logic flush_go;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_last;
        logic work;
        logic emit;
        logic pend_valid;
        logic out_free;
        logic last_ij;
    } status_t;

endpackage

// File: rtl/uint8_max_pool_argmax_dequant.sv
// top level: uint8 max pooling with argmax and fixed-point dequantization
//
// input stream s_*: one uint8 pixel per transfer, raster order, planes back to back.
// output stream m_*: one pooled window per transfer, in raster order of the windows;
// m_tlast marks the final window completed by a given pixel.
// configuration: cfg_wr_en/cfg_index/cfg_wdata write one register per cycle, no read-back;
// write only while the block is idle.
// per pixel the block takes an accept step, a restoring divide of XW bits (XW =
// clog2(max dim + 3), 11 at the default 1024 limits) for the window index of row and
// column and a setup step; for every window that holds the pixel it then does a ram
// read, an update/write and a hand-off, and it ends with a flush step; a pixel that
// lies in no window skips the window steps and the flush.
// the divider and the read-modify-write of the partial window memory set the pace.
// a finished result moves to a pending slot and then to an output register; the block
// keeps working and only waits when the pending slot is full and the receiver still
// holds the output register.
// reset (aresetn low, synchronous) restores the register defaults and zeroes the
// counters; the partial window memory needs no clearing.
module uint8_max_pool_argmax_dequant #(
    parameter int MAX_WIDTH  = mpad_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mpad_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_POOL   = mpad_pkg::MAX_POOL_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [mpad_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mpad_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // pixel[7:0]
    input  logic [mpad_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pooled_value[7:0], out_row[17:8], out_col[27:18], plane_number[43:28],
    // argmax_row[53:44], argmax_col[63:54], dequant_value[96:64], zero fill
    output logic [mpad_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                            m_tlast
);

    localparam int CB = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int PB = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
    localparam int AW = PB + CB;

    mpad_pkg::cmd_t    cmd;
    mpad_pkg::status_t status;

    logic                         ram_rd_en, ram_wr_en;
    logic [AW-1:0]                ram_rd_addr, ram_wr_addr;
    logic [mpad_pkg::ENTRY_W-1:0] ram_rd_data, ram_wr_data;

    // controller
    mpad_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    mpad_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_POOL   (MAX_POOL)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .pixel       (s_tdata[mpad_pkg::PIXEL_W-1:0]),
        .cmd         (cmd),
        .status      (status),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    // partial window store, one row of entries per window row slot
    mpad_ram #(
        .WIDTH (mpad_pkg::ENTRY_W),
        .DEPTH (1 << AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

// File: rtl/mpad_ram.sv
// generic simple dual-port ram with registered read
module mpad_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/mpad_ctrl.sv
// sequencer for pixel accept, window divide, window walk and result flush
module mpad_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  mpad_pkg::status_t status,
    output mpad_pkg::cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_DIV   = 7'b0000010,
        ST_BOUND = 7'b0000100,
        ST_WADDR = 7'b0001000,
        ST_WUPD  = 7'b0010000,
        ST_CAND  = 7'b0100000,
        ST_FLUSH = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   cand_block;
    logic   flush_block;

    // a result waits when the pending one cannot leave yet
    assign cand_block  = status.emit && status.pend_valid && !status.out_free;
    assign flush_block = status.pend_valid && !status.out_free;

    // commands
    always_comb begin
        cmd          = '0;
        cmd.accept   = (state_reg == ST_IDLE) && s_tvalid;
        cmd.div_step = (state_reg == ST_DIV);
        cmd.bound    = (state_reg == ST_BOUND);
        cmd.waddr    = (state_reg == ST_WADDR);
        cmd.wupd     = (state_reg == ST_WUPD);
        cmd.cand_go  = (state_reg == ST_CAND) && !cand_block;
        cmd.flush_go = (state_reg == ST_FLUSH) && !flush_block;
    end

    assign s_tready = (state_reg == ST_IDLE);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DIV;
            end
            ST_DIV: begin
                if (status.div_last) state_next = ST_BOUND;
            end
            ST_BOUND: begin
                state_next = status.work ? ST_WADDR : ST_IDLE;
            end
            ST_WADDR: begin
                state_next = ST_WUPD;
            end
            ST_WUPD: begin
                state_next = ST_CAND;
            end
            ST_CAND: begin
                if (!cand_block) state_next = status.last_ij ? ST_FLUSH : ST_WADDR;
            end
            ST_FLUSH: begin
                if (!flush_block) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/mpad_dpath.sv
// datapath: config, counters, window divider, partial window update, output stage
module mpad_dpath #(
    parameter int MAX_WIDTH  = mpad_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mpad_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_POOL   = mpad_pkg::MAX_POOL_DEF,
    localparam int CB = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int PB = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1,
    localparam int AW = PB + CB
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [mpad_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mpad_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic [mpad_pkg::PIXEL_W-1:0]      pixel,
    input  mpad_pkg::cmd_t                    cmd,
    output mpad_pkg::status_t                 status,
    output logic                              ram_rd_en,
    output logic [AW-1:0]                     ram_rd_addr,
    input  logic [mpad_pkg::ENTRY_W-1:0]      ram_rd_data,
    output logic                              ram_wr_en,
    output logic [AW-1:0]                     ram_wr_addr,
    output logic [mpad_pkg::ENTRY_W-1:0]      ram_wr_data,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [mpad_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tlast
);

    localparam int MAXD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int XW   = $clog2(MAXD + 3);
    localparam int XW3  = XW + 3;
    localparam int SW   = (XW + 5 > 13) ? XW + 5 : 13;
    localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CW   = CB;
    localparam int NW   = $clog2(XW + 1);
    localparam logic signed [SW-1:0] S_ONE  = SW'(1);
    localparam logic signed [SW-1:0] S_ZERO = '0;

    // configuration registers
    logic [10:0] in_width_reg, in_height_reg;
    logic [3:0]  pool_reg, stride_reg;
    logic [2:0]  pad_reg;
    logic [7:0]  zp_reg;
    logic [23:0] scale_reg;
    logic        deq_en_reg;

    // position counters
    logic [CW-1:0] col_cnt_reg;
    logic [RW-1:0] row_cnt_reg;
    logic [15:0]   plane_cnt_reg;

    // current pixel
    logic [7:0]    px_reg;
    logic [RW-1:0] cur_r_reg;
    logic [CW-1:0] cur_c_reg;
    logic [15:0]   cur_plane_reg;
    logic          in_plane_reg;

    // divider, index 0 rows and index 1 columns
    logic [XW-1:0] dvd_reg [2];
    logic [2:0]    rem_reg [2];
    logic [XW-1:0] quo_reg [2];
    logic [NW-1:0] div_cnt_reg;
    logic [XW-1:0] lo_reg  [2];

    // window walk
    logic [XW-1:0] i_reg, j_reg;
    logic          valid_reg, first_reg, lastw_reg;
    logic [AW-1:0] addr_reg;

    // candidate and pending results
    mpad_pkg::entry_t cand_reg, pend_reg;
    logic [XW-1:0]    cand_i_reg, cand_j_reg, pend_i_reg, pend_j_reg;
    logic             emit_reg, pend_valid_reg;

    // output stage
    logic                            m_valid_reg, m_last_reg;
    logic [mpad_pkg::OUT_DATA_W-1:0] m_data_reg;

    // clamped geometry
    logic [3:0]             k_u, s_u;
    logic [1:0]             off_u;
    logic signed [SW-1:0]   w_s, h_s, k_s, s_s, off_s, pad_s, dw, dh;

    always_comb begin
        if (in_width_reg == '0) w_s = S_ONE;
        else if (int'(in_width_reg) > MAX_WIDTH) w_s = SW'(MAX_WIDTH);
        else w_s = $signed(SW'(in_width_reg));
        if (in_height_reg == '0) h_s = S_ONE;
        else if (int'(in_height_reg) > MAX_HEIGHT) h_s = SW'(MAX_HEIGHT);
        else h_s = $signed(SW'(in_height_reg));
        if (pool_reg == '0) k_u = 4'd1;
        else if (int'(pool_reg) > MAX_POOL) k_u = 4'(MAX_POOL);
        else k_u = pool_reg;
        s_u   = (stride_reg == '0) ? 4'd1 : stride_reg;
        off_u = pad_reg[2:1];
        k_s   = $signed(SW'(k_u));
        s_s   = $signed(SW'(s_u));
        off_s = $signed(SW'(off_u));
        pad_s = $signed(SW'(pad_reg));
        dw    = w_s + pad_s - k_s;
        dh    = h_s + pad_s - k_s;
    end

    // counter wrap at the plane bounds
    logic signed [SW-1:0] row_s, col_s;
    logic col_wrap, row_wrap;

    assign row_s    = $signed(SW'(row_cnt_reg));
    assign col_s    = $signed(SW'(col_cnt_reg));
    assign col_wrap = (col_s >= w_s - S_ONE);
    assign row_wrap = (row_s >= h_s - S_ONE);

    // one restoring divide step per axis
    logic [3:0] rem_sh  [2];
    logic       rem_ge  [2];
    logic [2:0] rem_new [2];

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            rem_sh[a]  = {rem_reg[a], dvd_reg[a][XW-1]};
            rem_ge[a]  = (rem_sh[a] >= s_u);
            rem_new[a] = rem_ge[a] ? 3'(rem_sh[a] - s_u) : 3'(rem_sh[a]);
        end
    end

    // first window containing the pixel along each axis
    logic signed [4:0] km      [2];
    logic              none_ax [2];
    logic [2:0]        mcnt    [2];
    logic [XW-1:0]     lo_new  [2];

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            km[a]      = $signed({1'b0, k_u - 4'd1}) - $signed({2'b00, rem_reg[a]});
            none_ax[a] = km[a][4];
            mcnt[a]    = '0;
            for (int m = 1; m < 8; m++) begin
                if (!none_ax[a] && ((7'(m) * 7'(s_u)) <= 7'(km[a][3:0]))) begin
                    mcnt[a] = 3'(mcnt[a] + 3'd1);
                end
            end
            if (XW3'(mcnt[a]) > XW3'(quo_reg[a])) lo_new[a] = '0;
            else lo_new[a] = quo_reg[a] - XW'(mcnt[a]);
        end
    end

    // geometry of window (i, j)
    logic signed [SW-1:0] i_s, j_s, ims, jms, rs, re, cs, ce, fr, lr, fc, lc;
    logic signed [SW-1:0] cr_s, cc_s;
    logic                 row_ok, col_ok, first_hit, last_hit;

    always_comb begin
        i_s  = $signed(SW'(i_reg));
        j_s  = $signed(SW'(j_reg));
        ims  = i_s * s_s;
        jms  = j_s * s_s;
        rs   = ims - off_s;
        re   = rs + k_s - S_ONE;
        cs   = jms - off_s;
        ce   = cs + k_s - S_ONE;
        fr   = (rs < S_ZERO) ? S_ZERO : rs;
        lr   = (re > h_s - S_ONE) ? h_s - S_ONE : re;
        fc   = (cs < S_ZERO) ? S_ZERO : cs;
        lc   = (ce > w_s - S_ONE) ? w_s - S_ONE : ce;
        cr_s = $signed(SW'(cur_r_reg));
        cc_s = $signed(SW'(cur_c_reg));
        row_ok = (((dh >= S_ZERO) && (ims <= dh)) || ((i_reg == '0) && (dh > -s_s)))
                 && (i_s < $signed(SW'(MAX_HEIGHT)));
        col_ok = (((dw >= S_ZERO) && (jms <= dw)) || ((j_reg == '0) && (dw > -s_s)))
                 && (j_s < $signed(SW'(MAX_WIDTH)));
        first_hit = (cr_s == fr) && (cc_s == fc);
        last_hit  = (cr_s == lr) && (cc_s == lc);
    end

    // read-modify-write of the partial entry
    mpad_pkg::entry_t rd_e, mine_e, upd_e;

    always_comb begin
        rd_e         = mpad_pkg::entry_t'(ram_rd_data);
        mine_e.value = px_reg;
        mine_e.row   = mpad_pkg::COORD_W'(cur_r_reg);
        mine_e.col   = mpad_pkg::COORD_W'(cur_c_reg);
        if (first_reg || (px_reg > rd_e.value)) upd_e = mine_e;
        else upd_e = rd_e;
    end

    assign ram_rd_en   = cmd.waddr;
    assign ram_rd_addr = {PB'(i_reg), CB'(j_reg)};
    assign ram_wr_en   = cmd.wupd && valid_reg;
    assign ram_wr_addr = addr_reg;
    assign ram_wr_data = upd_e;

    // result push from the pending slot
    logic out_free, push, push_last;

    assign out_free  = !m_valid_reg || m_tready;
    assign push      = pend_valid_reg && ((cmd.cand_go && emit_reg) || cmd.flush_go);
    assign push_last = cmd.flush_go;

    // dequantize the pending value
    logic signed [8:0]  dq_diff;
    logic signed [33:0] dq_prod;
    logic [32:0]        dq_val;

    assign dq_diff = $signed({1'b0, pend_reg.value}) - $signed({1'b0, zp_reg});
    assign dq_prod = 34'(dq_diff) * $signed({10'b0, scale_reg});
    assign dq_val  = deq_en_reg ? dq_prod[32:0] : '0;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_width_reg   <= 11'd1;
            in_height_reg  <= 11'd1;
            pool_reg       <= 4'd2;
            stride_reg     <= 4'd2;
            pad_reg        <= '0;
            zp_reg         <= '0;
            scale_reg      <= 24'd65536;
            deq_en_reg     <= 1'b0;
            col_cnt_reg    <= '0;
            row_cnt_reg    <= '0;
            plane_cnt_reg  <= '0;
            div_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            // register writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    mpad_pkg::REG_IN_WIDTH:  in_width_reg  <= cfg_wdata[10:0];
                    mpad_pkg::REG_IN_HEIGHT: in_height_reg <= cfg_wdata[10:0];
                    mpad_pkg::REG_POOL_SIZE: pool_reg      <= cfg_wdata[3:0];
                    mpad_pkg::REG_STRIDE:    stride_reg    <= cfg_wdata[3:0];
                    mpad_pkg::REG_PAD:       pad_reg       <= cfg_wdata[2:0];
                    mpad_pkg::REG_ZERO_PT:   zp_reg        <= cfg_wdata[7:0];
                    mpad_pkg::REG_SCALE:     scale_reg     <= cfg_wdata[23:0];
                    mpad_pkg::REG_DEQ_EN:    deq_en_reg    <= cfg_wdata[0];
                    default: ;
                endcase
            end
            // raster counters advance on each input transfer
            if (cmd.accept) begin
                if (col_wrap) begin
                    col_cnt_reg <= '0;
                    if (row_wrap) begin
                        row_cnt_reg   <= '0;
                        plane_cnt_reg <= plane_cnt_reg + 16'd1;
                    end else begin
                        row_cnt_reg <= row_cnt_reg + RW'(1);
                    end
                end else begin
                    col_cnt_reg <= col_cnt_reg + CW'(1);
                end
                div_cnt_reg <= NW'(XW);
            end else if (cmd.div_step) begin
                div_cnt_reg <= div_cnt_reg - NW'(1);
            end
            // pending slot
            if (cmd.cand_go && emit_reg) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.flush_go) begin
                pend_valid_reg <= 1'b0;
            end
            // output valid
            if (push) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            px_reg        <= pixel;
            cur_r_reg     <= row_cnt_reg;
            cur_c_reg     <= col_cnt_reg;
            cur_plane_reg <= plane_cnt_reg;
            in_plane_reg  <= (row_s < h_s) && (col_s < w_s);
            dvd_reg[0]    <= XW'(row_cnt_reg) + XW'(off_u);
            dvd_reg[1]    <= XW'(col_cnt_reg) + XW'(off_u);
            for (int a = 0; a < 2; a++) begin
                rem_reg[a] <= '0;
                quo_reg[a] <= '0;
            end
        end else if (cmd.div_step) begin
            for (int a = 0; a < 2; a++) begin
                dvd_reg[a] <= dvd_reg[a] << 1;
                rem_reg[a] <= rem_new[a];
                quo_reg[a] <= {quo_reg[a][XW-2:0], rem_ge[a]};
            end
        end
        // start of the window walk
        if (cmd.bound) begin
            lo_reg[0] <= lo_new[0];
            lo_reg[1] <= lo_new[1];
            i_reg     <= lo_new[0];
            j_reg     <= lo_new[1];
        end
        // window flags and address
        if (cmd.waddr) begin
            valid_reg <= row_ok && col_ok;
            first_reg <= first_hit;
            lastw_reg <= last_hit;
            addr_reg  <= {PB'(i_reg), CB'(j_reg)};
        end
        // capture the updated entry as a result candidate
        if (cmd.wupd) begin
            cand_reg   <= upd_e;
            cand_i_reg <= i_reg;
            cand_j_reg <= j_reg;
            emit_reg   <= valid_reg && lastw_reg;
        end
        // move to the next window
        if (cmd.cand_go) begin
            if (emit_reg) begin
                pend_reg   <= cand_reg;
                pend_i_reg <= cand_i_reg;
                pend_j_reg <= cand_j_reg;
            end
            if (j_reg == quo_reg[1]) begin
                j_reg <= lo_reg[1];
                i_reg <= i_reg + XW'(1);
            end else begin
                j_reg <= j_reg + XW'(1);
            end
        end
        // output transfer register
        if (push) begin
            m_last_reg <= push_last;
            m_data_reg <= {7'b0, dq_val, pend_reg.col, pend_reg.row, cur_plane_reg,
                           mpad_pkg::COORD_W'(pend_j_reg), mpad_pkg::COORD_W'(pend_i_reg),
                           pend_reg.value};
        end
    end

    // status
    always_comb begin
        status            = '0;
        status.div_last   = (div_cnt_reg == NW'(1));
        status.work       = in_plane_reg && !none_ax[0] && !none_ax[1];
        status.emit       = emit_reg;
        status.pend_valid = pend_valid_reg;
        status.out_free   = out_free;
        status.last_ij    = (i_reg == quo_reg[0]) && (j_reg == quo_reg[1]);
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

// File: test/mpad_checker.sv
// checker for the max pooling block: tracks config writes, predicts pooled windows, compares results
module mpad_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [mpad_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mpad_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [mpad_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [mpad_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            m_tlast,
    output int                              err_count,
    output int                              windows_pending,
    output int                              windows_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MPOOL = mpad_pkg::MAX_POOL_DEF;
    localparam int MW    = mpad_pkg::MAX_WIDTH_DEF;
    localparam int MH    = mpad_pkg::MAX_HEIGHT_DEF;
    localparam int DEPTH = MPOOL * MW;

    typedef int win_list_t [MPOOL];

    typedef struct {
        logic [7:0]  val;
        logic [9:0]  orow;
        logic [9:0]  ocol;
        logic [15:0] plane;
        logic [9:0]  arow;
        logic [9:0]  acol;
        logic [32:0] dq;
        logic        last;
    } pool_result_t;

    // shadow registers
    logic [10:0] r_width, r_height;
    logic [3:0]  r_pool, r_stride;
    logic [2:0]  r_pad;
    logic [7:0]  r_zp;
    logic [23:0] r_scale;
    logic        r_deq;

    // shadow position counters and partial window memory
    int unsigned col_pos, row_pos;
    logic [15:0] plane_pos;
    logic [27:0] win_store [DEPTH];

    pool_result_t window_q [$];

    assign windows_pending = window_q.size();

    function automatic int clampd(int v, int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int win_count(int n, int k, int s, int p, int cap);
        int d, r;
        d = n + p - k;
        if (d >= 0) r = d / s + 1;
        else r = (-d < s) ? 1 : 0;
        return (r > cap) ? cap : r;
    endfunction

    // windows along one axis that hold position x, ascending
    function automatic int axis_windows(int x, int off, int k, int s, int limit,
                                        output win_list_t lst);
        win_list_t tmp;
        int cnt, w, q;
        cnt = 0;
        w = (x + off) / s;
        while (cnt < MPOOL) begin
            if (w * s + k - 1 < x + off) break;
            if (w < limit) begin
                tmp[cnt] = w;
                cnt++;
            end
            if (w == 0) break;
            w--;
        end
        for (q = 0; q < cnt; q++) lst[q] = tmp[cnt - 1 - q];
        return cnt;
    endfunction

    // update the partial windows for one pixel and queue every window it completes
    task automatic predict_pixel(input logic [7:0] px);
        int W, H, K, S, off, ow, oh, r, c, nr, nc, n, a, b, i, j;
        int rs, re, fr, lr, cs, ce, fc, lc, idx;
        logic [27:0] e, mine;
        win_list_t rows, cols;
        pool_result_t res, held;
        bit have_held;
        longint prod;
        W = clampd(r_width, MW);
        H = clampd(r_height, MH);
        K = clampd(r_pool, MPOOL);
        S = (r_stride == 0) ? 1 : r_stride;
        off = r_pad / 2;
        ow = win_count(W, K, S, r_pad, MW);
        oh = win_count(H, K, S, r_pad, MH);
        r = row_pos;
        c = col_pos;
        n = 0;
        have_held = 0;
        if (r < H && c < W) begin
            nr = axis_windows(r, off, K, S, oh, rows);
            nc = axis_windows(c, off, K, S, ow, cols);
            for (a = 0; a < nr; a++) begin
                i = rows[a];
                rs = i * S - off;
                re = rs + K - 1;
                fr = (rs < 0) ? 0 : rs;
                lr = (re > H - 1) ? H - 1 : re;
                for (b = 0; b < nc; b++) begin
                    j = cols[b];
                    cs = j * S - off;
                    ce = cs + K - 1;
                    fc = (cs < 0) ? 0 : cs;
                    lc = (ce > W - 1) ? W - 1 : ce;
                    idx = (i % MPOOL) * MW + j;
                    mine = {c[9:0], r[9:0], px};
                    if (idx >= DEPTH) continue;
                    // first valid pixel opens the window, strictly greater replaces
                    if (r == fr && c == fc) begin
                        e = mine;
                    end else begin
                        e = win_store[idx];
                        if (px > e[7:0]) e = mine;
                    end
                    win_store[idx] = e;
                    if (r == lr && c == lc && n < MPOOL * MPOOL) begin
                        res.val   = e[7:0];
                        res.orow  = i[9:0];
                        res.ocol  = j[9:0];
                        res.plane = plane_pos;
                        res.arow  = e[17:8];
                        res.acol  = e[27:18];
                        res.dq    = '0;
                        if (r_deq) begin
                            prod = (longint'(e[7:0]) - longint'(r_zp)) * longint'(r_scale);
                            res.dq = prod[32:0];
                        end
                        res.last = 1'b0;
                        if (have_held) window_q.push_back(held);
                        held = res;
                        have_held = 1;
                        n++;
                    end
                end
            end
            if (have_held) begin
                held.last = 1'b1;
                window_q.push_back(held);
            end
        end
        // raster counters wrap at the current bounds
        if (c >= W - 1) begin
            col_pos = 0;
            if (r >= H - 1) begin
                row_pos = 0;
                plane_pos = plane_pos + 16'd1;
            end else begin
                row_pos = r + 1;
            end
        end else begin
            col_pos = c + 1;
        end
    endtask

    function automatic void check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $display("%0t mismatch %s: expected 0x%0h actual 0x%0h", $time, name, exp_v, act_v);
            err_count++;
        end
    endfunction

    always @(posedge aclk) begin
        pool_result_t want;
        if (!aresetn) begin
            r_width = 11'd1; r_height = 11'd1; r_pool = 4'd2; r_stride = 4'd2;
            r_pad = 3'd0; r_zp = 8'd0; r_scale = 24'd65536; r_deq = 1'b0;
            col_pos = 0; row_pos = 0; plane_pos = '0;
            err_count = 0;
            windows_seen = 0;
            window_q.delete();
        end else begin
            // register writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    mpad_pkg::REG_IN_WIDTH:  r_width  = cfg_wdata[10:0];
                    mpad_pkg::REG_IN_HEIGHT: r_height = cfg_wdata[10:0];
                    mpad_pkg::REG_POOL_SIZE: r_pool   = cfg_wdata[3:0];
                    mpad_pkg::REG_STRIDE:    r_stride = cfg_wdata[3:0];
                    mpad_pkg::REG_PAD:       r_pad    = cfg_wdata[2:0];
                    mpad_pkg::REG_ZERO_PT:   r_zp     = cfg_wdata[7:0];
                    mpad_pkg::REG_SCALE:     r_scale  = cfg_wdata[23:0];
                    mpad_pkg::REG_DEQ_EN:    r_deq    = cfg_wdata[0];
                    default: ;
                endcase
            end
            // result transfer checked against the oldest prediction
            if (m_tvalid && m_tready) begin
                windows_seen++;
                if (window_q.size() == 0) begin
                    $display("%0t unexpected result: expected none actual 0x%0h", $time, m_tdata);
                    err_count++;
                end else begin
                    want = window_q.pop_front();
                    check_field("pooled_value", want.val, m_tdata[7:0]);
                    check_field("out_row", want.orow, m_tdata[17:8]);
                    check_field("out_col", want.ocol, m_tdata[27:18]);
                    check_field("plane_number", want.plane, m_tdata[43:28]);
                    check_field("argmax_row", want.arow, m_tdata[53:44]);
                    check_field("argmax_col", want.acol, m_tdata[63:54]);
                    check_field("dequant_value", want.dq, m_tdata[96:64]);
                    check_field("zero_fill", 0, m_tdata[103:97]);
                    check_field("last_of_run", want.last, m_tlast);
                end
            end
            // pixel transfer
            if (s_tvalid && s_tready) predict_pixel(s_tdata);
        end
    end

endmodule

// File: test/tb_uint8_max_pool_argmax_dequant.sv
// testbench top: drives pixels and register settings, gives the verdict from the checker
module tb_uint8_max_pool_argmax_dequant;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 40000;
    localparam int DRAIN_WAIT  = 400;
    localparam int RAND_PIXELS = 230;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [mpad_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [mpad_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [mpad_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [mpad_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            m_tlast;

    int  err_count, windows_pending, windows_seen;
    int  pixels_sent = 0;
    int  phases_run = 0;
    int  idle_cycles = 0;
    bit  calm = 0;
    bit  const_pixels = 0;
    logic [7:0] const_val;

    uint8_max_pool_argmax_dequant u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    mpad_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .err_count(err_count), .windows_pending(windows_pending),
        .windows_seen(windows_seen)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 7);
    end

    // watchdog on cycles with no transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int clamp_dim(int v, int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic write_reg(input logic [mpad_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[mpad_pkg::CFG_DATA_W-1:0];
        @(posedge aclk);
    endtask

    task automatic send_pixel(input logic [7:0] px);
        int gap;
        gap = 0;
        while (!calm && $urandom_range(99) < 7) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pixels_sent++;
    endtask

    function automatic logic [7:0] pick_pixel();
        if (const_pixels) return const_val;
        case ($urandom_range(3))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // set all registers while idle, then stream whole planes
    task automatic run_phase(input int w, input int h, input int k, input int s,
                             input int p, input int zp, input int sc, input int de,
                             input int planes);
        int n, q;
        wait (windows_pending == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        write_reg(mpad_pkg::REG_IN_WIDTH, w);
        write_reg(mpad_pkg::REG_IN_HEIGHT, h);
        write_reg(mpad_pkg::REG_POOL_SIZE, k);
        write_reg(mpad_pkg::REG_STRIDE, s);
        write_reg(mpad_pkg::REG_PAD, p);
        write_reg(mpad_pkg::REG_ZERO_PT, zp);
        write_reg(mpad_pkg::REG_SCALE, sc);
        write_reg(mpad_pkg::REG_DEQ_EN, de);
        cfg_wr_en <= 1'b0;
        n = clamp_dim(w & 16'h7FF, mpad_pkg::MAX_WIDTH_DEF)
            * clamp_dim(h & 16'h7FF, mpad_pkg::MAX_HEIGHT_DEF) * planes;
        for (q = 0; q < n; q++) send_pixel(pick_pixel());
        s_tvalid <= 1'b0;
        @(posedge aclk);
        phases_run++;
    endtask

    initial begin
        int rand_start;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset defaults on single-pixel planes
        calm = 1;
        repeat (3) send_pixel(pick_pixel());
        s_tvalid <= 1'b0;
        @(posedge aclk);
        calm = 0;
        // plain 2x2 pooling, extremes of the pixel range
        run_phase(4, 4, 2, 2, 0, 0, 65536, 1, 1);
        // overlapping windows, maximum zero point and scale
        run_phase(5, 4, 3, 1, 2, 255, 24'hFFFFFF, 1, 1);
        // ties: equal values keep the first position
        const_pixels = 1;
        const_val = 8'd200;
        run_phase(3, 3, 2, 1, 1, 100, 12345, 1, 1);
        const_pixels = 0;
        // zero geometry registers treated as one, padding-only windows dropped
        run_phase(0, 0, 0, 0, 7, 0, 0, 1, 2);
        // oversized pool saturates, no window fits
        run_phase(12, 1, 15, 1, 0, 5, 65536, 0, 1);
        // tall narrow plane, largest pool with stride equal to the pool, receiver never stalls
        calm = 1;
        run_phase(1, 48, 8, 8, 7, 128, 3, 1, 1);
        calm = 0;
        // many windows end on the same pixel
        run_phase(8, 8, 8, 1, 7, 0, 1, 1, 1);

        // random geometries with small planes
        rand_start = pixels_sent;
        while (pixels_sent - rand_start < RAND_PIXELS) begin
            calm = ($urandom_range(5) == 0);
            const_pixels = ($urandom_range(9) == 0);
            const_val = 8'($urandom);
            run_phase($urandom_range(8, 1), $urandom_range(8, 1), $urandom_range(8, 1),
                      $urandom_range(8, 1), $urandom_range(7), $urandom_range(255),
                      $urandom_range(24'hFFFFFF), $urandom_range(1), $urandom_range(2, 1));
        end
        calm = 0;
        const_pixels = 0;

        wait (windows_pending == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("covered %0d pixels in %0d register settings, %0d pooled windows checked",
                 pixels_sent, phases_run, windows_seen);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", err_count);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
